>>> src/gnmg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnmg_pkg
// Shared sizes, command codes and register indexes of the map smoothing block.
// ----------------------------------------------------------------------------
package gnmg_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  // Address widths into the map.
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);

  // Count widths: wide enough for the 7-bit registers and for MAX itself.
  localparam int CFG_W     = 7;
  localparam int ROW_CNT_W = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
  localparam int COL_CNT_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

  localparam int          NBR_W          = 4;
  localparam logic [NBR_W-1:0] GROW_THRESHOLD = NBR_W'(5);

  // Command codes.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_PASS  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Register indexes.
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

endpackage
`default_nettype wire

>>> src/grid_neighbor_majority_grow.sv
`timescale 1ns / 1ps
`default_nettype none
// A cell write or read fetches its row word, then patches it (S_RMW) or reads the bit
// (S_RD); unknown kinds and no-interior passes go straight to the result state S_RESP.
// A pass over R x C rows/cols in use loads rows 0 and 1 first, then does
// one interior cell update per cycle plus one row load and one write-back per row.
// One item in flight; the next is taken while the previous beat waits at the output.
// Reset: map reads as all clear (per-row valid flags), counts return to 64.
// ----------------------------------------------------------------------------
// grid_neighbor_majority_grow
// Binary occupancy map with cell write/read and an in-place 3x3 grow pass.
// ----------------------------------------------------------------------------
module grid_neighbor_majority_grow import gnmg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Command channel
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [1:0]       kind_i,
  input  wire logic [5:0]       row_i,
  input  wire logic [5:0]       col_i,
  input  wire logic             cell_in_i,
  // Result channel
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  cell_out_o,
  output logic                  done_res_o,
  // Configuration channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic             cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RMW  = 4'd1;  // cell write: row word arrives, patch it
  localparam logic [3:0] S_RD   = 4'd2;  // cell read: row word arrives
  localparam logic [3:0] S_L0   = 4'd3;  // pass: row 0 arrives into the upper buffer
  localparam logic [3:0] S_L1   = 4'd4;  // pass: row 1 arrives into the center buffer
  localparam logic [3:0] S_L2   = 4'd5;  // pass: next lower row arrives
  localparam logic [3:0] S_CELL = 4'd6;  // pass: one interior cell per cycle
  localparam logic [3:0] S_WB   = 4'd7;  // pass: center row back to the map, shift window
  localparam logic [3:0] S_RESP = 4'd8;  // hand the result to the output register

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [CFG_W-1:0] row_count_q, col_count_q;

  // Map: one word per row, registered read. Rows never written read clear.
  logic [MAX_COLS-1:0] map_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_q;
  logic [MAX_COLS-1:0] rdata_q;
  logic                rvld_q;
  logic                mem_re, mem_we;
  logic [ROW_W-1:0]    mem_raddr, mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [MAX_COLS-1:0] rd_word;

  // Latched command.
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             val_q, val_d;

  // Pass window: upper row is already updated, center is being updated.
  logic [MAX_COLS-1:0] up_q, up_d, cur_q, cur_d, dn_q, dn_d;
  logic [ROW_W-1:0]    r_q, r_d;
  logic [COL_W-1:0]    c_q, c_d;

  // Pending result and output register.
  logic res_cell_q, res_cell_d, res_done_q, res_done_d;
  logic out_valid_q, out_valid_d, cell_out_q, cell_out_d, done_out_q, done_out_d;

  logic [ROW_CNT_W-1:0] nr;
  logic [COL_CNT_W-1:0] nc;
  logic                 in_range, no_interior, in_fire, out_free;
  logic [8:0]           nbr;
  logic [NBR_W-1:0]     nbr_cnt;

  // Counts in use, clamped to the map size.
  assign nr = (ROW_CNT_W'(row_count_q) > ROW_CNT_W'(MAX_ROWS))
              ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(row_count_q);
  assign nc = (COL_CNT_W'(col_count_q) > COL_CNT_W'(MAX_COLS))
              ? COL_CNT_W'(MAX_COLS) : COL_CNT_W'(col_count_q);

  assign in_range    = (ROW_CNT_W'(row_i) < nr) && (COL_CNT_W'(col_i) < nc);
  assign no_interior = (nr < ROW_CNT_W'(3)) || (nc < COL_CNT_W'(3));

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = cell_out_q;
  assign done_res_o  = done_out_q;

  assign rd_word = rvld_q ? rdata_q : '0;

  // 3x3 neighborhood around column c of the window.
  assign nbr = {up_q[c_q - COL_W'(1)],  up_q[c_q],  up_q[c_q + COL_W'(1)],
                cur_q[c_q - COL_W'(1)], cur_q[c_q], cur_q[c_q + COL_W'(1)],
                dn_q[c_q - COL_W'(1)],  dn_q[c_q],  dn_q[c_q + COL_W'(1)]};
  assign nbr_cnt = NBR_W'($countones(nbr));

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    val_d      = val_q;
    up_d       = up_q;
    cur_d      = cur_q;
    dn_d       = dn_q;
    r_d        = r_q;
    c_d        = c_q;
    res_cell_d = res_cell_q;
    res_done_d = res_done_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = r_q;
    mem_wdata  = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          row_d      = ROW_W'(row_i);
          col_d      = COL_W'(col_i);
          val_d      = cell_in_i;
          res_cell_d = 1'b0;
          res_done_d = 1'b1;
          state_d    = S_RESP;
          case (kind_i)
            KIND_WRITE: begin
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = ROW_W'(row_i);
                state_d   = S_RMW;
              end
            end
            KIND_READ: begin
              if (in_range) begin
                mem_re    = 1'b1;
                mem_raddr = ROW_W'(row_i);
                state_d   = S_RD;
              end
            end
            KIND_PASS: begin
              if (!no_interior) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                r_d       = ROW_W'(1);
                state_d   = S_L0;
              end
            end
            default: res_done_d = 1'b0;
          endcase
        end
      end
      S_RMW: begin
        mem_we           = 1'b1;
        mem_waddr        = row_q;
        mem_wdata        = rd_word;
        mem_wdata[col_q] = val_q;
        state_d          = S_RESP;
      end
      S_RD: begin
        res_cell_d = rd_word[col_q];
        state_d    = S_RESP;
      end
      S_L0: begin
        up_d      = rd_word;
        mem_re    = 1'b1;
        mem_raddr = ROW_W'(1);
        state_d   = S_L1;
      end
      S_L1: begin
        cur_d     = rd_word;
        mem_re    = 1'b1;
        mem_raddr = ROW_W'(2);
        state_d   = S_L2;
      end
      S_L2: begin
        dn_d    = rd_word;
        c_d     = COL_W'(1);
        state_d = S_CELL;
      end
      S_CELL: begin
        // Grow only; left neighbor in cur_q already carries its new value.
        if (nbr_cnt >= GROW_THRESHOLD) begin
          cur_d[c_q] = 1'b1;
        end
        if (COL_CNT_W'(c_q) == nc - COL_CNT_W'(2)) begin
          state_d = S_WB;
        end else begin
          c_d = c_q + COL_W'(1);
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = r_q;
        mem_wdata = cur_q;
        up_d      = cur_q;
        cur_d     = dn_q;
        if (ROW_CNT_W'(r_q) == nr - ROW_CNT_W'(2)) begin
          state_d = S_RESP;
        end else begin
          // Row r+2 is ahead of every write of this pass: no hazard.
          r_d       = r_q + ROW_W'(1);
          mem_re    = 1'b1;
          mem_raddr = r_q + ROW_W'(2);
          state_d   = S_L2;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: loads when the result slot frees up.
  always_comb begin
    out_valid_d = out_valid_q;
    cell_out_d  = cell_out_q;
    done_out_d  = done_out_q;
    if (state_q == S_RESP && out_free) begin
      out_valid_d = 1'b1;
      cell_out_d  = res_cell_q;
      done_out_d  = res_done_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      row_count_q <= CFG_W'(64);
      col_count_q <= CFG_W'(64);
      row_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ROW_COUNT: row_count_q <= cfg_data_i;
          REG_COL_COUNT: col_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (mem_we) begin
        row_vld_q[mem_waddr] <= 1'b1;
      end
    end
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    col_q      <= col_d;
    val_q      <= val_d;
    up_q       <= up_d;
    cur_q      <= cur_d;
    dn_q       <= dn_d;
    r_q        <= r_d;
    c_q        <= c_d;
    res_cell_q <= res_cell_d;
    res_done_q <= res_done_d;
    cell_out_q <= cell_out_d;
    done_out_q <= done_out_d;
  end

  // Map memory.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[mem_raddr];
      rvld_q  <= row_vld_q[mem_raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/gnmg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gnmg_checker
// Port-level checks of the map smoothing block, bound to the top level.
// ----------------------------------------------------------------------------
module gnmg_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic cell_out_o,
  input wire logic done_res_o,
  input wire logic cfg_ready_o
);

  // A waiting beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_out_o) && $stable(done_res_o))
    else $error("result beat changed while stalled");

  // Unknown command never reports a cell.
  a_nop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> !cell_out_o)
    else $error("cell_out set without done");

  // One item at a time: an accepted command closes the input.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted back to back");

  // No result can appear without an earlier accepted command.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result beat with idle block");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port stalled");

endmodule

bind grid_neighbor_majority_grow gnmg_checker u_gnmg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .cell_out_o (cell_out_o),
  .done_res_o (done_res_o),
  .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire
